>>> sv/modular_arithmetic_unit_assert.svh
// Assertion macros for the modular arithmetic unit.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define MAU_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define MAU_ASSERT(lbl, prop)
`define MAU_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

>>> sv/mau_pkg.sv
// Shared types and constants of the modular arithmetic unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package mau_pkg;

  localparam int unsigned MOD_WIDTH = 31;
  localparam int unsigned EXP_W     = 63;
  localparam int unsigned CNT_W     = $clog2(MOD_WIDTH);
  localparam logic [MOD_WIDTH-1:0] MOD_RESET = 31'd1000000007;

  typedef enum logic [2:0] {
    K_ADD = 3'd0, K_SUB = 3'd1, K_MUL = 3'd2, K_DIV = 3'd3,
    K_NEG = 3'd4, K_POW = 3'd5, K_SQRT = 3'd6, K_INV = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    OP_NOP, OP_LOAD, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_INC, OP_MINNEG
  } op_e;

  typedef enum logic [3:0] {
    SEL_A, SEL_B, SEL_X, SEL_Y, SEL_Z, SEL_T, SEL_ACC, SEL_SQ, SEL_ZERO, SEL_ONE
  } sel_e;

  typedef enum logic [1:0] {EOP_NOP, EOP_LOAD, EOP_SHR} eop_e;

  typedef enum logic [2:0] {ES_MM2, ES_HALF, ES_QHALF, ES_Q, ES_POW2} esel_e;

  typedef struct packed {
    op_e   op;
    sel_e  dst;
    sel_e  src1;
    sel_e  src2;
    eop_e  eop;
    esel_e esel;
    logic  q_init;
    logic  q_shift;
    logic  j_clr;
    logic  j_inc;
    logic  e_from_j;
  } cmd_t;

  typedef struct packed {
    logic mm_done;
    logic exp_zero;
    logic exp_lsb;
    logic a_zero;
    logic b_zero;
    logic acc_one;
    logic y_one;
    logic t_one;
    logic b_ge_m;
    logic q_even;
    logic j_lt_e;
    logic mod_lt2;
    logic mod_two;
  } stat_t;

endpackage
`default_nettype wire

>>> sv/modular_arithmetic_unit.sv
// Top level of the modular arithmetic unit: stream ports, modulus register,
// output register. Depends on mau_pkg, mau_ctrl and mau_datapath.
//
//  port group   dir  payload
//  s_axis_*     in   tuser: kind; tdata: operand_a, operand_b, exponent
//  m_axis_*     out  tdata: result
//  APB p*       in   register 0 at byte 0: modulus (31 bits)
//
// One beat at a time. Every modular multiply runs on one shift-add unit;
// the two operand reductions use it as well. Pow: a squaring per exponent
// bit and a further multiply per set bit. Inverse/divide similar with
// exponent m-2. Square root: several exponentiations plus the non-residue
// search, so it scales with that search.
// Reset is asynchronous, active low; the modulus returns to 1000000007.
// A finished result waits in the output register; the next beat is taken
// as soon as the sequencer is idle, whether or not the result was read.
`default_nettype none
module modular_arithmetic_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [30:0] operand_a, [61:31] operand_b, [124:62] exponent, [127:125] zero
  input  logic [127:0] s_axis_tdata,
  // [2:0] kind
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [30:0] result, [31] zero
  output logic [31:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import mau_pkg::*;

  logic [MOD_WIDTH-1:0] mod_q, res_q, dp_result;
  logic                 m_valid_q;
  logic                 in_fire, idle, out_load, out_free;
  cmd_t                 cmd;
  stat_t                stat;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {1'b0, mod_q};

  // modulus register; paddr[2] set falls outside the register map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MOD_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      mod_q <= pwdata[MOD_WIDTH-1:0];
    end
  end

  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  mau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .kind_i     (kind_e'(s_axis_tuser)),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idle_o     (idle),
    .out_load_o (out_load)
  );

  mau_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .in_a_i   (s_axis_tdata[30:0]),
    .in_b_i   (s_axis_tdata[61:31]),
    .in_exp_i (s_axis_tdata[124:62]),
    .mod_i    (mod_q),
    .stat_o   (stat),
    .result_o (dp_result)
  );

  // output register: parts the result from the next beat's work
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) res_q <= dp_result;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};

endmodule
`default_nettype wire

>>> sv/mau_mulmod.sv
// Bit-serial modular multiplier: x*y mod m, one bit of y per cycle.
// Depends on mau_pkg and the assertion macro header.
`default_nettype none
`include "modular_arithmetic_unit_assert.svh"
module mau_mulmod (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mau_pkg::MOD_WIDTH-1:0]  x_i,
  input  logic [mau_pkg::MOD_WIDTH-1:0]  y_i,
  input  logic [mau_pkg::MOD_WIDTH-1:0]  m_i,
  output logic                           done_o,
  output logic [mau_pkg::MOD_WIDTH-1:0]  res_o
);
  import mau_pkg::*;

  localparam logic [CNT_W-1:0] LastStep = CNT_W'(MOD_WIDTH - 1);

  logic [MOD_WIDTH-1:0] acc_q, x_q, y_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q;
  logic [MOD_WIDTH:0]   dbl, dbl_r, sum, sum_r, m_ext;

  // x must be below m; y is any bit pattern (acc stays below m)
  always_comb begin
    m_ext = {1'b0, m_i};
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum   = dbl_r + (y_q[MOD_WIDTH-1] ? {1'b0, x_q} : '0);
    sum_r = (sum >= m_ext) ? sum - m_ext : sum;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      acc_q <= '0;
      cnt_q <= '0;
    end else if (busy_q) begin
      acc_q <= sum_r[MOD_WIDTH-1:0];
      y_q   <= y_q << 1;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == LastStep)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

  `MAU_ASSERT_MSG(a_start_idle, start_i |-> !busy_q, "multiply started while busy")
  `MAU_ASSERT(a_res_reduced, (done_q && (m_i >= MOD_WIDTH'(2))) |-> (acc_q < m_i))

endmodule
`default_nettype wire

>>> sv/mau_datapath.sv
// Register file, adder/subtractor, exponent and counter registers and the
// shared multiplier. Depends on mau_pkg and mau_mulmod.
`default_nettype none
module mau_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mau_pkg::cmd_t                 cmd_i,
  input  logic [mau_pkg::MOD_WIDTH-1:0] in_a_i,
  input  logic [mau_pkg::MOD_WIDTH-1:0] in_b_i,
  input  logic [mau_pkg::EXP_W-1:0]     in_exp_i,
  input  logic [mau_pkg::MOD_WIDTH-1:0] mod_i,
  output mau_pkg::stat_t                stat_o,
  output logic [mau_pkg::MOD_WIDTH-1:0] result_o
);
  import mau_pkg::*;

  logic [MOD_WIDTH-1:0] a_q, b_q, x_q, y_q, z_q, t_q, acc_q, sq_q, q_q;
  logic [EXP_W-1:0]     exp_q;
  logic [CNT_W-1:0]     e_q, j_q;
  sel_e                 dst_q;

  logic [MOD_WIDTH-1:0] s1, s2, alu_res, mm_res, neg, wdata;
  logic [MOD_WIDTH:0]   add_w, sub_w, m_ext;
  logic                 alu_we, mm_done, wen;
  sel_e                 wsel;

  always_comb begin
    case (cmd_i.src1)
      SEL_A:   s1 = a_q;
      SEL_B:   s1 = b_q;
      SEL_X:   s1 = x_q;
      SEL_Y:   s1 = y_q;
      SEL_Z:   s1 = z_q;
      SEL_T:   s1 = t_q;
      SEL_ACC: s1 = acc_q;
      SEL_SQ:  s1 = sq_q;
      SEL_ONE: s1 = MOD_WIDTH'(1);
      default: s1 = '0;
    endcase
    case (cmd_i.src2)
      SEL_A:   s2 = a_q;
      SEL_B:   s2 = b_q;
      SEL_X:   s2 = x_q;
      SEL_Y:   s2 = y_q;
      SEL_Z:   s2 = z_q;
      SEL_T:   s2 = t_q;
      SEL_ACC: s2 = acc_q;
      SEL_SQ:  s2 = sq_q;
      SEL_ONE: s2 = MOD_WIDTH'(1);
      default: s2 = '0;
    endcase
  end

  always_comb begin
    m_ext = {1'b0, mod_i};
    add_w = {1'b0, s1} + {1'b0, s2};
    if (add_w >= m_ext) add_w = add_w - m_ext;
    sub_w = {1'b0, s1} - {1'b0, s2};
    if (s1 < s2) sub_w = sub_w + m_ext;
    neg   = mod_i - s1;
    alu_we = 1'b1;
    case (cmd_i.op)
      OP_MOV:    alu_res = s1;
      OP_ADD:    alu_res = add_w[MOD_WIDTH-1:0];
      OP_SUB:    alu_res = sub_w[MOD_WIDTH-1:0];
      OP_INC:    alu_res = s1 + MOD_WIDTH'(1);
      OP_MINNEG: alu_res = (s1 < neg) ? s1 : neg;
      default: begin
        alu_res = '0;
        alu_we  = 1'b0;
      end
    endcase
    wen   = alu_we || mm_done;
    wsel  = mm_done ? dst_q : cmd_i.dst;
    wdata = mm_done ? mm_res : alu_res;
  end

  mau_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_MUL),
    .x_i     (s1),
    .y_i     (s2),
    .m_i     (mod_i),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MUL) dst_q <= cmd_i.dst;
    if (cmd_i.op == OP_LOAD) begin
      a_q <= in_a_i;
      b_q <= in_b_i;
    end else if (wen) begin
      case (wsel)
        SEL_A:   a_q   <= wdata;
        SEL_B:   b_q   <= wdata;
        SEL_X:   x_q   <= wdata;
        SEL_Y:   y_q   <= wdata;
        SEL_Z:   z_q   <= wdata;
        SEL_T:   t_q   <= wdata;
        SEL_ACC: acc_q <= wdata;
        SEL_SQ:  sq_q  <= wdata;
        default: ;
      endcase
    end

    if (cmd_i.op == OP_LOAD) begin
      exp_q <= in_exp_i;
    end else if (cmd_i.eop == EOP_SHR) begin
      exp_q <= exp_q >> 1;
    end else if (cmd_i.eop == EOP_LOAD) begin
      case (cmd_i.esel)
        ES_MM2:   exp_q <= EXP_W'(mod_i - MOD_WIDTH'(2));
        ES_HALF:  exp_q <= EXP_W'((mod_i - MOD_WIDTH'(1)) >> 1);
        ES_QHALF: exp_q <= EXP_W'((q_q - MOD_WIDTH'(1)) >> 1);
        ES_Q:     exp_q <= EXP_W'(q_q);
        ES_POW2:  exp_q <= EXP_W'(1) << (e_q - j_q - CNT_W'(1));
        default:  exp_q <= '0;
      endcase
    end

    // trailing-zero split of m-1 for the root search
    if (cmd_i.q_init) begin
      q_q <= mod_i - MOD_WIDTH'(1);
      e_q <= '0;
    end else if (cmd_i.q_shift) begin
      q_q <= q_q >> 1;
      e_q <= e_q + 1'b1;
    end else if (cmd_i.e_from_j) begin
      e_q <= j_q;
    end
    if (cmd_i.j_clr) j_q <= '0;
    else if (cmd_i.j_inc) j_q <= j_q + 1'b1;
  end

  always_comb begin
    stat_o.mm_done  = mm_done;
    stat_o.exp_zero = (exp_q == '0);
    stat_o.exp_lsb  = exp_q[0];
    stat_o.a_zero   = (a_q == '0);
    stat_o.b_zero   = (b_q == '0);
    stat_o.acc_one  = (acc_q == MOD_WIDTH'(1));
    stat_o.y_one    = (y_q == MOD_WIDTH'(1));
    stat_o.t_one    = (t_q == MOD_WIDTH'(1));
    stat_o.b_ge_m   = (b_q >= mod_i);
    stat_o.q_even   = (q_q != '0) && !q_q[0];
    stat_o.j_lt_e   = (j_q < e_q);
    stat_o.mod_lt2  = (mod_i < MOD_WIDTH'(2));
    stat_o.mod_two  = (mod_i == MOD_WIDTH'(2));
  end

  assign result_o = acc_q;

endmodule
`default_nettype wire

>>> sv/mau_ctrl.sv
// Sequencer: steps the datapath through each operation, with a shared
// square-and-multiply routine. Depends on mau_pkg and the assertion header.
`default_nettype none
`include "modular_arithmetic_unit_assert.svh"
module mau_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  mau_pkg::kind_e kind_i,
  input  logic           out_free_i,
  input  mau_pkg::stat_t stat_i,
  output mau_pkg::cmd_t  cmd_o,
  output logic           idle_o,
  output logic           out_load_o
);
  import mau_pkg::*;

  typedef enum logic [26:0] {
    S_IDLE     = 27'd1 << 0,
    S_WAIT     = 27'd1 << 1,
    S_CHECK    = 27'd1 << 2,
    S_RED_B    = 27'd1 << 3,
    S_DISPATCH = 27'd1 << 4,
    S_DIV_MUL  = 27'd1 << 5,
    S_POW_INIT = 27'd1 << 6,
    S_POW_TEST = 27'd1 << 7,
    S_POW_SQ   = 27'd1 << 8,
    S_DONE     = 27'd1 << 9,
    S_SQ_PRE   = 27'd1 << 10,
    S_SQ_LEG   = 27'd1 << 11,
    S_SQ_BTEST = 27'd1 << 12,
    S_SQ_BCHK  = 27'd1 << 13,
    S_SQ_QLOOP = 27'd1 << 14,
    S_SQ_X     = 27'd1 << 15,
    S_SQ_Y1    = 27'd1 << 16,
    S_SQ_Y2    = 27'd1 << 17,
    S_SQ_ZP    = 27'd1 << 18,
    S_SQ_Z     = 27'd1 << 19,
    S_SQ_XA    = 27'd1 << 20,
    S_SQ_LOOP  = 27'd1 << 21,
    S_SQ_INNER = 27'd1 << 22,
    S_SQ_ZU    = 27'd1 << 23,
    S_SQ_ZZ    = 27'd1 << 24,
    S_SQ_YZ    = 27'd1 << 25,
    S_SQ_FIN   = 27'd1 << 26
  } state_e;

  state_e state_q, state_d, ret_q, ret_d, pret_q, pret_d;
  kind_e  kind_q, kind_d;

  function automatic cmd_t mk(op_e op, sel_e d, sel_e s1, sel_e s2);
    cmd_t c;
    c      = '0;
    c.op   = op;
    c.dst  = d;
    c.src1 = s1;
    c.src2 = s2;
    return c;
  endfunction

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    ret_d      = ret_q;
    pret_d     = pret_q;
    kind_d     = kind_q;
    out_load_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          cmd_o.op = OP_LOAD;
          kind_d   = kind_i;
          state_d  = S_CHECK;
        end
      end
      S_WAIT: begin
        if (stat_i.mm_done) state_d = ret_q;
      end
      S_CHECK: begin
        if (stat_i.mod_lt2) begin
          cmd_o   = mk(OP_MOV, SEL_ACC, SEL_ZERO, SEL_ZERO);
          state_d = S_DONE;
        end else begin
          cmd_o   = mk(OP_MUL, SEL_A, SEL_ONE, SEL_A);
          ret_d   = S_RED_B;
          state_d = S_WAIT;
        end
      end
      S_RED_B: begin
        cmd_o   = mk(OP_MUL, SEL_B, SEL_ONE, SEL_B);
        ret_d   = S_DISPATCH;
        state_d = S_WAIT;
      end
      S_DISPATCH: begin
        case (kind_q)
          K_ADD: begin
            cmd_o   = mk(OP_ADD, SEL_ACC, SEL_A, SEL_B);
            state_d = S_DONE;
          end
          K_SUB: begin
            cmd_o   = mk(OP_SUB, SEL_ACC, SEL_A, SEL_B);
            state_d = S_DONE;
          end
          K_MUL: begin
            cmd_o   = mk(OP_MUL, SEL_ACC, SEL_A, SEL_B);
            ret_d   = S_DONE;
            state_d = S_WAIT;
          end
          K_NEG: begin
            cmd_o   = mk(OP_SUB, SEL_ACC, SEL_ZERO, SEL_A);
            state_d = S_DONE;
          end
          K_POW: begin
            cmd_o   = mk(OP_MOV, SEL_SQ, SEL_A, SEL_ZERO);
            pret_d  = S_DONE;
            state_d = S_POW_INIT;
          end
          K_INV: begin
            if (stat_i.a_zero) begin
              cmd_o   = mk(OP_MOV, SEL_ACC, SEL_ZERO, SEL_ZERO);
              state_d = S_DONE;
            end else begin
              cmd_o      = mk(OP_MOV, SEL_SQ, SEL_A, SEL_ZERO);
              cmd_o.eop  = EOP_LOAD;
              cmd_o.esel = ES_MM2;
              pret_d     = S_DONE;
              state_d    = S_POW_INIT;
            end
          end
          K_DIV: begin
            if (stat_i.b_zero) begin
              cmd_o   = mk(OP_MOV, SEL_ACC, SEL_ZERO, SEL_ZERO);
              state_d = S_DONE;
            end else begin
              cmd_o      = mk(OP_MOV, SEL_SQ, SEL_B, SEL_ZERO);
              cmd_o.eop  = EOP_LOAD;
              cmd_o.esel = ES_MM2;
              pret_d     = S_DIV_MUL;
              state_d    = S_POW_INIT;
            end
          end
          K_SQRT: state_d = S_SQ_PRE;
          default: state_d = S_IDLE;
        endcase
      end
      S_DIV_MUL: begin
        cmd_o   = mk(OP_MUL, SEL_ACC, SEL_A, SEL_ACC);
        ret_d   = S_DONE;
        state_d = S_WAIT;
      end
      // square-and-multiply: base in SQ, exponent in EXP, result in ACC
      S_POW_INIT: begin
        cmd_o   = mk(OP_MOV, SEL_ACC, SEL_ONE, SEL_ZERO);
        state_d = S_POW_TEST;
      end
      S_POW_TEST: begin
        if (stat_i.exp_zero) begin
          state_d = pret_q;
        end else if (stat_i.exp_lsb) begin
          cmd_o   = mk(OP_MUL, SEL_ACC, SEL_ACC, SEL_SQ);
          ret_d   = S_POW_SQ;
          state_d = S_WAIT;
        end else begin
          state_d = S_POW_SQ;
        end
      end
      S_POW_SQ: begin
        cmd_o     = mk(OP_MUL, SEL_SQ, SEL_SQ, SEL_SQ);
        cmd_o.eop = EOP_SHR;
        ret_d     = S_POW_TEST;
        state_d   = S_WAIT;
      end
      // Tonelli-Shanks
      S_SQ_PRE: begin
        if (stat_i.a_zero) begin
          cmd_o   = mk(OP_MOV, SEL_ACC, SEL_ZERO, SEL_ZERO);
          state_d = S_DONE;
        end else if (stat_i.mod_two) begin
          cmd_o   = mk(OP_MOV, SEL_ACC, SEL_A, SEL_ZERO);
          state_d = S_DONE;
        end else begin
          cmd_o      = mk(OP_MOV, SEL_SQ, SEL_A, SEL_ZERO);
          cmd_o.eop  = EOP_LOAD;
          cmd_o.esel = ES_HALF;
          pret_d     = S_SQ_LEG;
          state_d    = S_POW_INIT;
        end
      end
      S_SQ_LEG: begin
        if (!stat_i.acc_one) begin
          cmd_o   = mk(OP_MOV, SEL_ACC, SEL_ZERO, SEL_ZERO);
          state_d = S_DONE;
        end else begin
          cmd_o   = mk(OP_MOV, SEL_B, SEL_ONE, SEL_ZERO);
          state_d = S_SQ_BTEST;
        end
      end
      S_SQ_BTEST: begin
        if (stat_i.b_ge_m) begin
          cmd_o   = mk(OP_MOV, SEL_ACC, SEL_ZERO, SEL_ZERO);
          state_d = S_DONE;
        end else begin
          cmd_o      = mk(OP_MOV, SEL_SQ, SEL_B, SEL_ZERO);
          cmd_o.eop  = EOP_LOAD;
          cmd_o.esel = ES_HALF;
          pret_d     = S_SQ_BCHK;
          state_d    = S_POW_INIT;
        end
      end
      S_SQ_BCHK: begin
        if (stat_i.acc_one) begin
          cmd_o   = mk(OP_INC, SEL_B, SEL_B, SEL_ZERO);
          state_d = S_SQ_BTEST;
        end else begin
          cmd_o.q_init = 1'b1;
          state_d      = S_SQ_QLOOP;
        end
      end
      S_SQ_QLOOP: begin
        if (stat_i.q_even) begin
          cmd_o.q_shift = 1'b1;
        end else begin
          cmd_o      = mk(OP_MOV, SEL_SQ, SEL_A, SEL_ZERO);
          cmd_o.eop  = EOP_LOAD;
          cmd_o.esel = ES_QHALF;
          pret_d     = S_SQ_X;
          state_d    = S_POW_INIT;
        end
      end
      S_SQ_X: begin
        cmd_o   = mk(OP_MOV, SEL_X, SEL_ACC, SEL_ZERO);
        state_d = S_SQ_Y1;
      end
      S_SQ_Y1: begin
        cmd_o   = mk(OP_MUL, SEL_Y, SEL_A, SEL_X);
        ret_d   = S_SQ_Y2;
        state_d = S_WAIT;
      end
      S_SQ_Y2: begin
        cmd_o   = mk(OP_MUL, SEL_Y, SEL_Y, SEL_X);
        ret_d   = S_SQ_ZP;
        state_d = S_WAIT;
      end
      S_SQ_ZP: begin
        cmd_o      = mk(OP_MOV, SEL_SQ, SEL_B, SEL_ZERO);
        cmd_o.eop  = EOP_LOAD;
        cmd_o.esel = ES_Q;
        pret_d     = S_SQ_Z;
        state_d    = S_POW_INIT;
      end
      S_SQ_Z: begin
        cmd_o   = mk(OP_MOV, SEL_Z, SEL_ACC, SEL_ZERO);
        state_d = S_SQ_XA;
      end
      S_SQ_XA: begin
        cmd_o   = mk(OP_MUL, SEL_X, SEL_X, SEL_A);
        ret_d   = S_SQ_LOOP;
        state_d = S_WAIT;
      end
      S_SQ_LOOP: begin
        if (stat_i.y_one) begin
          state_d = S_SQ_FIN;
        end else begin
          cmd_o       = mk(OP_MOV, SEL_T, SEL_Y, SEL_ZERO);
          cmd_o.j_clr = 1'b1;
          state_d     = S_SQ_INNER;
        end
      end
      S_SQ_INNER: begin
        if (!stat_i.t_one && stat_i.j_lt_e) begin
          cmd_o       = mk(OP_MUL, SEL_T, SEL_T, SEL_T);
          cmd_o.j_inc = 1'b1;
          ret_d       = S_SQ_INNER;
          state_d     = S_WAIT;
        end else if (!stat_i.t_one || !stat_i.j_lt_e) begin
          cmd_o   = mk(OP_MOV, SEL_ACC, SEL_ZERO, SEL_ZERO);
          state_d = S_DONE;
        end else begin
          cmd_o      = mk(OP_MOV, SEL_SQ, SEL_Z, SEL_ZERO);
          cmd_o.eop  = EOP_LOAD;
          cmd_o.esel = ES_POW2;
          pret_d     = S_SQ_ZU;
          state_d    = S_POW_INIT;
        end
      end
      S_SQ_ZU: begin
        cmd_o   = mk(OP_MUL, SEL_X, SEL_X, SEL_ACC);
        ret_d   = S_SQ_ZZ;
        state_d = S_WAIT;
      end
      S_SQ_ZZ: begin
        cmd_o   = mk(OP_MUL, SEL_Z, SEL_ACC, SEL_ACC);
        ret_d   = S_SQ_YZ;
        state_d = S_WAIT;
      end
      S_SQ_YZ: begin
        cmd_o          = mk(OP_MUL, SEL_Y, SEL_Y, SEL_Z);
        cmd_o.e_from_j = 1'b1;
        ret_d          = S_SQ_LOOP;
        state_d        = S_WAIT;
      end
      S_SQ_FIN: begin
        cmd_o   = mk(OP_MINNEG, SEL_ACC, SEL_X, SEL_ZERO);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      pret_q  <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      pret_q  <= pret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign idle_o = (state_q == S_IDLE);

  `MAU_ASSERT_MSG(a_busy_after_accept, in_fire_i |=> !idle_o, "accepted beat not taken up")

endmodule
`default_nettype wire
